>>> hw/rtl/dtvc_pkg.sv
// Shared types and constants for the directed triangle vertex counter.
package dtvc_pkg;

    localparam int IDX_W        = 6;
    localparam int VC_W         = 7;
    localparam int TALLY_W      = 7;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [VC_W-1:0]    VC_RESET  = 7'd64;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 7'd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_LOAD,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } dtvc_state_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] pos;
        logic             val;
    } dtvc_upd_t;

endpackage

>>> hw/rtl/directed_triangle_vertex_count_top.sv
// Top level of the directed triangle vertex counter.
//
//  channel  dir  tdata bits (low first)                   side bits
//  s_       in   row_index[5:0] col_index[11:6]           tlast = last_entry
//                edge_bit[12], zero[15:13]
//  m_       out  vertices_on_cycle[6:0], zero[7]          -
//  cfg_     in   cfg_wdata = vertex_count                 cfg_we
//
//  Matrix entries are taken one per cycle; each does a read-modify-write of
//  its row word and column word, with the previous write forwarded.
//  After the entry marked last, the count runs over n = min(vertex_count,
//  MAX_VERTICES) rows, one row-memory read per cycle.
//  No entry is accepted during the count or while it waits on m_tready.
//  aresetn is synchronous, active low; the matrix memories are not cleared.
module directed_triangle_vertex_count_top #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // row_index[5:0], col_index[11:6], edge_bit[12], zero[15:13]
    input  logic [dtvc_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // vertices_on_cycle[6:0], zero[7]
    output logic [dtvc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [dtvc_pkg::VC_W-1:0]             cfg_wdata
);
    import dtvc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    dtvc_state_t             state_reg, state_next;

    logic [VC_W-1:0]         vertex_count_reg;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           u_reg, u_next;
    logic [MAX_VERTICES-1:0] mask_reg, mask_next;
    logic [MAX_VERTICES-1:0] row_i_reg, col_i_reg;
    logic                    tst_valid_reg;
    logic [CW-1:0]           tst_u_reg;
    logic                    found_reg, found_next;
    logic [TALLY_W-1:0]      tally_reg, tally_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [TALLY_W-1:0]      m_tdata_reg, m_tdata_next;

    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic                    in_edge;
    logic                    in_fire;
    logic                    in_range;
    logic                    out_free;
    logic                    hit;
    logic                    row_done;
    logic                    last_u;
    logic                    last_i;

    dtvc_upd_t               upd_row;
    dtvc_upd_t               upd_col;
    logic [AW-1:0]           rows_rd_addr;
    logic [AW-1:0]           cols_rd_addr;
    logic [MAX_VERTICES-1:0] rows_q;
    logic [MAX_VERTICES-1:0] cols_q;

    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign in_edge  = s_tdata[2*IDX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_range = (32'(in_row) < 32'(MAX_VERTICES)) && (32'(in_col) < 32'(MAX_VERTICES));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        upd_row.valid = in_fire && in_range;
        upd_row.addr  = in_row;
        upd_row.pos   = in_col;
        upd_row.val   = in_edge && (in_row != in_col);
        upd_col.valid = upd_row.valid;
        upd_col.addr  = in_col;
        upd_col.pos   = in_row;
        upd_col.val   = upd_row.val;
    end

    dtvc_bitmem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_rows (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd_row),
        .rd_addr (rows_rd_addr),
        .rd_data (rows_q)
    );

    dtvc_bitmem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_cols (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd_col),
        .rd_addr (cols_rd_addr),
        .rd_data (cols_q)
    );

    assign hit = tst_valid_reg && row_i_reg[tst_u_reg[AW-1:0]]
                 && (|(rows_q & col_i_reg & mask_reg));
    assign last_u = (u_reg == CW'(n_reg - CW'(1)));
    assign last_i = (i_reg == CW'(n_reg - CW'(1)));
    assign row_done = found_reg || hit;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_tlast) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = (n_reg == '0) ? ST_DONE : ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (last_u) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = last_i ? ST_DONE : ST_LOAD;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_next        = n_reg;
        i_next        = i_reg;
        u_next        = u_reg;
        mask_next     = mask_reg;
        found_next    = found_reg;
        tally_next    = tally_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rows_rd_addr  = u_reg[AW-1:0];
        cols_rd_addr  = i_reg[AW-1:0];
        if (hit) begin
            found_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_tlast) begin
                    n_next = (32'(vertex_count_reg) > 32'(MAX_VERTICES)) ?
                             CW'(MAX_VERTICES) : CW'(vertex_count_reg);
                end
            end
            ST_FLUSH: begin
                for (int k = 0; k < MAX_VERTICES; k++) begin
                    mask_next[k] = (32'(k) < 32'(n_reg));
                end
                i_next     = '0;
                tally_next = '0;
            end
            ST_LOAD: begin
                rows_rd_addr = i_reg[AW-1:0];
                u_next       = '0;
                found_next   = 1'b0;
            end
            ST_SCAN: begin
                u_next = CW'(u_reg + CW'(1));
            end
            ST_TAIL: begin
                if (row_done && (tally_reg != TALLY_MAX)) begin
                    tally_next = TALLY_W'(tally_reg + TALLY_W'(1));
                end
                i_next = CW'(i_reg + CW'(1));
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = tally_reg;
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= VC_RESET;
            tally_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
            tst_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            m_tvalid_reg  <= m_tvalid_next;
            tst_valid_reg <= (state_reg == ST_SCAN);
            found_reg     <= found_next;
            if (cfg_we) begin
                vertex_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        u_reg       <= u_next;
        mask_reg    <= mask_next;
        tst_u_reg   <= u_reg;
        m_tdata_reg <= m_tdata_next;
        if ((state_reg == ST_SCAN) && (u_reg == '0)) begin
            row_i_reg <= rows_q;
            col_i_reg <= cols_q;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_tdata_reg);

endmodule

>>> hw/rtl/dtvc_bitmem.sv
// Adjacency word memory with single-bit read-modify-write and write forwarding.
module dtvc_bitmem #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dtvc_pkg::dtvc_upd_t              upd,
    input  logic [$clog2(MAX_VERTICES)-1:0]  rd_addr,
    output logic [MAX_VERTICES-1:0]          rd_data
);
    import dtvc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int IW = (AW > IDX_W) ? AW : IDX_W;

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] rd_data_reg;

    logic [IW-1:0]           upd_addr_ext;
    logic [IW-1:0]           upd_pos_ext;
    logic [AW-1:0]           rd_sel;

    logic                    st_valid_reg;
    logic [AW-1:0]           st_addr_reg;
    logic [AW-1:0]           st_pos_reg;
    logic                    st_val_reg;

    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [MAX_VERTICES-1:0] fwd_data_reg;

    logic [MAX_VERTICES-1:0] base_word;
    logic [MAX_VERTICES-1:0] wr_word;

    assign upd_addr_ext = IW'(upd.addr);
    assign upd_pos_ext  = IW'(upd.pos);
    assign rd_sel       = upd.valid ? upd_addr_ext[AW-1:0] : rd_addr;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_sel];
        if (st_valid_reg) begin
            mem[st_addr_reg] <= wr_word;
        end
    end

    // take the word just written when the memory still returns the old one
    always_comb begin
        base_word = rd_data_reg;
        if (fwd_valid_reg && (fwd_addr_reg == st_addr_reg)) begin
            base_word = fwd_data_reg;
        end
        wr_word             = base_word;
        wr_word[st_pos_reg] = st_val_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= upd.valid;
            fwd_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        st_addr_reg  <= upd_addr_ext[AW-1:0];
        st_pos_reg   <= upd_pos_ext[AW-1:0];
        st_val_reg   <= upd.val;
        fwd_addr_reg <= st_addr_reg;
        fwd_data_reg <= wr_word;
    end

    assign rd_data = rd_data_reg;

endmodule
